// ===== rtl/auto_gain_level_tracker_macros.svh =====
// assertion macros for the auto gain level tracker
`ifndef AUTO_GAIN_LEVEL_TRACKER_MACROS_SVH
`define AUTO_GAIN_LEVEL_TRACKER_MACROS_SVH

// same-cycle implication check
`define AGL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("agl same-cycle check failed");

// next-cycle implication check
`define AGL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("agl next-cycle check failed");

`endif

// ===== rtl/agl_pkg.sv =====
// shared constants, types and helpers of the auto gain level tracker
package agl_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF   = 16;
   localparam int LEVEL_WIDTH_DEF = 32;

   // fixed-point constants: -log2 of the nominal rates in Q.24, ln2 in Q.30
   localparam int          NEGLOG_W        = 26;
   localparam logic [25:0] NL2_ATTACK_UP   = 26'd38955489;
   localparam logic [25:0] NL2_ATTACK_DOWN = 26'd16777216;
   localparam logic [25:0] NL2_LONG_FAST   = 26'd2550189;
   localparam logic [25:0] NL2_LONG_SLOW   = 26'd194414;
   localparam logic [29:0] LN2_Q30         = 30'd744261118;
   localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
   localparam logic [7:0]  SHIFT_MAX       = 8'd30;
   localparam logic [3:0]  HORNER_TERMS    = 4'd10;

   // datapath widths
   localparam int RATE_W      = 31;
   localparam int QUOT_W      = 32;
   localparam int M_DIVIDEND_W = 42;
   localparam int FPS_W       = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_CONVERGE_FRAMES = 2'd0;
   localparam logic [1:0] CSR_REFERENCE_FPS   = 2'd1;
   localparam logic [7:0] CONVERGE_RESET      = 8'd50;
   localparam logic [7:0] REF_FPS_RESET       = 8'd30;

   // divider status back to the sequencer
   typedef struct packed {
      logic done;
      logic ovf;
   } div_stat_type;

   // sign and saturation of a ratio quotient
   function automatic logic [31:0] sat_ratio(input logic [31:0] q, input logic ovf,
                                             input logic neg);
      logic [31:0] mag;
      mag = (ovf || q[31]) ? 32'h8000_0000 : q;
      if (neg) begin
         sat_ratio = 32'd0 - mag;
      end else if (mag[31]) begin
         sat_ratio = 32'h7FFF_FFFF;
      end else begin
         sat_ratio = mag;
      end
   endfunction

endpackage

// ===== rtl/auto_gain_level_tracker.sv =====
// top level of the auto gain level tracker: sequencer, averages and ratio outputs
// One request (a level sample and the frame rate) is worked on at a time and
// gives one response. All arithmetic runs through one bit-serial multiplier
// and one bit-serial divider. Each of the two smoothing rates costs one
// multiply and one divide for the exponent, one multiply for the fraction, ten
// multiply/divide pairs for the series and one multiply for the average
// update; the two ratios cost one divide each. A rate whose exponent is out of
// range skips the series and is much shorter, and a long average near zero
// skips both ratio divides. A new request is taken while the previous response
// still waits on rsp_stall.
module auto_gain_level_tracker #(
   parameter int FRAC_BITS   = agl_pkg::FRAC_BITS_DEF,
   parameter int LEVEL_WIDTH = agl_pkg::LEVEL_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LEVEL_WIDTH-1:0] req_level_sample,
   input  logic [15:0]            req_frame_rate,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_sample_ratio,
   output logic [31:0]            rsp_average_ratio,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata
);

   `include "auto_gain_level_tracker_macros.svh"

   localparam int LW      = LEVEL_WIDTH;
   localparam int MUL_A_W = (LW > agl_pkg::RATE_W) ? LW : agl_pkg::RATE_W;
   localparam int MUL_B_W = agl_pkg::RATE_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = (LW + FRAC_BITS > agl_pkg::M_DIVIDEND_W) ?
                            (LW + FRAC_BITS) : agl_pkg::M_DIVIDEND_W;
   localparam int DIV_D_W = (LW > agl_pkg::FPS_W) ? LW : agl_pkg::FPS_W;
   localparam int EPS_I   = ((1 << FRAC_BITS) + 500) / 1000;
   localparam logic [LW-1:0] EPS    = LW'(EPS_I);
   localparam logic [31:0]   ONE_FX = 32'(1 << FRAC_BITS);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_RMUL  = 11'b000_0000_0010,
      S_RDIV  = 11'b000_0000_0100,
      S_XMUL  = 11'b000_0000_1000,
      S_HMUL  = 11'b000_0001_0000,
      S_HDIV  = 11'b000_0010_0000,
      S_BMUL  = 11'b000_0100_0000,
      S_CHECK = 11'b000_1000_0000,
      S_QDIV0 = 11'b001_0000_0000,
      S_QDIV1 = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic                   go_ff, go_in;
   logic                   phase_ff, phase_in;
   logic signed [LW-1:0]   smp_ff, smp_in;
   logic signed [LW-1:0]   short_ff, short_in;
   logic signed [LW-1:0]   long_ff, long_in;
   logic [15:0]            fps_ff, fps_in;
   logic [7:0]             cnt_ff, cnt_in;
   logic [7:0]             conv_ff, conv_in;
   logic [7:0]             ref_ff, ref_in;
   logic [4:0]             n_ff, n_in;
   logic [29:0]            x_ff, x_in;
   logic [30:0]            p_ff, p_in;
   logic [3:0]             k_ff, k_in;
   logic [30:0]            rate_ff, rate_in;
   logic [31:0]            r0_ff, r0_in;
   logic [31:0]            r1_ff, r1_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_sr_ff, rsp_sr_in;
   logic [31:0]            rsp_ar_ff, rsp_ar_in;

   logic                   mul_done;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      mul_prod;
   agl_pkg::div_stat_type  div_stat;
   logic [DIV_N_W-1:0]     div_n;
   logic [DIV_D_W-1:0]     div_d;
   logic [31:0]            div_q;

   logic [25:0]            neglog;
   logic signed [LW-1:0]   old_avg;
   logic [LW:0]            d_ext;
   logic                   d_neg;
   logic [LW:0]            u_ext;
   logic [LW-1:0]          t_val;
   logic [LW:0]            blend_ext;
   logic                   l_neg;
   logic [LW:0]            lmag_ext;
   logic [LW-1:0]          lmag;
   logic signed [LW-1:0]   num;
   logic                   n_neg;
   logic [LW:0]            nmag_ext;
   logic [30:0]            p_new;
   logic [31:0]            ratio_q;

   // rate selection and blend arithmetic
   always_comb begin
      if (phase_ff) begin
         neglog = (cnt_ff < conv_ff) ? agl_pkg::NL2_LONG_FAST : agl_pkg::NL2_LONG_SLOW;
      end else begin
         neglog = (smp_ff > short_ff) ? agl_pkg::NL2_ATTACK_UP : agl_pkg::NL2_ATTACK_DOWN;
      end
      old_avg   = phase_ff ? long_ff : short_ff;
      d_ext     = {old_avg[LW-1], old_avg} - {smp_ff[LW-1], smp_ff};
      d_neg     = d_ext[LW];
      u_ext     = d_neg ? ((LW+1)'(0) - d_ext) : d_ext;
      t_val     = mul_prod[30 +: LW];
      blend_ext = d_neg ? ({smp_ff[LW-1], smp_ff} - {1'b0, t_val})
                        : ({smp_ff[LW-1], smp_ff} + {1'b0, t_val});
      l_neg     = long_ff[LW-1];
      lmag_ext  = l_neg ? ((LW+1)'(0) - {long_ff[LW-1], long_ff}) : {long_ff[LW-1], long_ff};
      lmag      = lmag_ext[LW-1:0];
      num       = (state_ff == S_QDIV1) ? short_ff : smp_ff;
      n_neg     = num[LW-1];
      nmag_ext  = n_neg ? ((LW+1)'(0) - {num[LW-1], num}) : {num[LW-1], num};
      p_new     = agl_pkg::ONE_Q30 - div_q[30:0];
      ratio_q   = agl_pkg::sat_ratio(div_q, div_stat.ovf, n_neg != l_neg);
   end

   // operand steering into the shared units
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = '0;
      case (state_ff)
         S_RMUL: begin
            mul_a = MUL_A_W'(neglog);
            mul_b = MUL_B_W'(ref_ff);
         end
         S_XMUL: begin
            mul_a = MUL_A_W'(agl_pkg::LN2_Q30);
            mul_b = MUL_B_W'(div_q[23:0]);
         end
         S_HMUL: begin
            mul_a = MUL_A_W'(p_ff);
            mul_b = MUL_B_W'(x_ff);
         end
         S_BMUL: begin
            mul_a = MUL_A_W'(u_ext[LW-1:0]);
            mul_b = rate_ff;
         end
         S_RDIV: begin
            div_n = DIV_N_W'({mul_prod[33:0], 8'd0});
            div_d = DIV_D_W'(fps_ff);
         end
         S_HDIV: begin
            div_n = DIV_N_W'(mul_prod[60:30]);
            div_d = DIV_D_W'(k_ff);
         end
         S_QDIV0, S_QDIV1: begin
            div_n = DIV_N_W'({nmag_ext[LW-1:0], {FRAC_BITS{1'b0}}});
            div_d = DIV_D_W'(lmag);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      phase_in     = phase_ff;
      smp_in       = smp_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      fps_in       = fps_ff;
      cnt_in       = cnt_ff;
      conv_in      = conv_ff;
      ref_in       = ref_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      rate_in      = rate_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sr_in    = rsp_sr_ff;
      rsp_ar_in    = rsp_ar_ff;

      // configuration writes
      if (csr_write) begin
         if (csr_index == agl_pkg::CSR_CONVERGE_FRAMES) begin
            conv_in = csr_wdata;
         end else if (csr_index == agl_pkg::CSR_REFERENCE_FPS) begin
            ref_in = csr_wdata;
         end
      end

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               smp_in   = req_level_sample;
               fps_in   = (req_frame_rate == 16'd0) ? 16'd1 : req_frame_rate;
               phase_in = 1'b0;
               state_in = S_RMUL;
               go_in    = 1'b1;
            end
         end
         S_RMUL: begin
            if (mul_done) begin
               state_in = S_RDIV;
               go_in    = 1'b1;
            end
         end
         S_RDIV: begin
            if (div_stat.done) begin
               go_in = 1'b1;
               if (div_stat.ovf || (div_q[31:24] > agl_pkg::SHIFT_MAX)) begin
                  rate_in  = '0;
                  state_in = S_BMUL;
               end else begin
                  n_in     = div_q[28:24];
                  state_in = S_XMUL;
               end
            end
         end
         S_XMUL: begin
            if (mul_done) begin
               x_in     = mul_prod[53:24];
               p_in     = agl_pkg::ONE_Q30;
               k_in     = agl_pkg::HORNER_TERMS;
               state_in = S_HMUL;
               go_in    = 1'b1;
            end
         end
         S_HMUL: begin
            if (mul_done) begin
               state_in = S_HDIV;
               go_in    = 1'b1;
            end
         end
         S_HDIV: begin
            if (div_stat.done) begin
               go_in = 1'b1;
               if (k_ff == 4'd1) begin
                  rate_in  = p_new >> n_ff;
                  state_in = S_BMUL;
               end else begin
                  p_in     = p_new;
                  k_in     = k_ff - 4'd1;
                  state_in = S_HMUL;
               end
            end
         end
         S_BMUL: begin
            if (mul_done) begin
               if (!phase_ff) begin
                  short_in = blend_ext[LW-1:0];
                  phase_in = 1'b1;
                  state_in = S_RMUL;
                  go_in    = 1'b1;
               end else begin
                  long_in  = blend_ext[LW-1:0];
                  cnt_in   = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if ((lmag == '0) || (lmag < EPS)) begin
               r0_in    = ONE_FX;
               r1_in    = ONE_FX;
               state_in = S_OUT;
            end else begin
               state_in = S_QDIV0;
               go_in    = 1'b1;
            end
         end
         S_QDIV0: begin
            if (div_stat.done) begin
               r0_in    = ratio_q;
               state_in = S_QDIV1;
               go_in    = 1'b1;
            end
         end
         S_QDIV1: begin
            if (div_stat.done) begin
               r1_in    = ratio_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sr_in    = r0_ff;
               rsp_ar_in    = r1_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         phase_ff     <= 1'b0;
         short_ff     <= '0;
         long_ff      <= '0;
         cnt_ff       <= '0;
         conv_ff      <= agl_pkg::CONVERGE_RESET;
         ref_ff       <= agl_pkg::REF_FPS_RESET;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         phase_ff     <= phase_in;
         short_ff     <= short_in;
         long_ff      <= long_in;
         cnt_ff       <= cnt_in;
         conv_ff      <= conv_in;
         ref_ff       <= ref_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      smp_ff    <= smp_in;
      fps_ff    <= fps_in;
      n_ff      <= n_in;
      x_ff      <= x_in;
      p_ff      <= p_in;
      rate_ff   <= rate_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      rsp_sr_ff <= rsp_sr_in;
      rsp_ar_ff <= rsp_ar_in;
   end

   // shared serial multiplier
   agl_ser_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff && (state_ff == S_RMUL || state_ff == S_XMUL ||
                          state_ff == S_HMUL || state_ff == S_BMUL)),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // shared serial divider
   agl_ser_div #(
      .N_W (DIV_N_W),
      .D_W (DIV_D_W),
      .Q_W (agl_pkg::QUOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff && (state_ff == S_RDIV || state_ff == S_HDIV ||
                           state_ff == S_QDIV0 || state_ff == S_QDIV1)),
      .dividend (div_n),
      .divisor  (div_d),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_ratio  = rsp_sr_ff;
   assign rsp_average_ratio = rsp_ar_ff;

   // checks
   `AGL_ASSERT_IMPL(a_units_exclusive, clock, reset, mul_done, !div_stat.done)
   `AGL_ASSERT_IMPL(a_horner_count, clock, reset, state_ff == S_HDIV,
                    k_ff != 4'd0 && k_ff <= agl_pkg::HORNER_TERMS)
   `AGL_ASSERT_IMPL(a_check_after_long, clock, reset, state_ff == S_CHECK, phase_ff)
   `AGL_ASSERT_NEXT(a_out_loads_rsp, clock, reset,
                    state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall),
                    rsp_valid_ff && state_ff == S_IDLE)

endmodule

// ===== rtl/agl_ser_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module agl_ser_mul #(
   parameter int A_W = 31,
   parameter int B_W = 31
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]     a_ff, a_in;
   logic [B_W-1:0]     b_ff, b_in;
   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_W:0]       sum;

   // add the multiplicand into the upper half, then shift right
   always_comb begin
      sum     = {1'b0, acc_ff[A_W+B_W-1:B_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[B_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/agl_ser_div.sv =====
// restoring bit-serial divider, one dividend bit per cycle, quotient overflow flag
module agl_ser_div #(
   parameter int N_W = 48,
   parameter int D_W = 32,
   parameter int Q_W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [N_W-1:0]       dividend,
   input  logic [D_W-1:0]       divisor,
   output agl_pkg::div_stat_type stat,
   output logic [Q_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   num_ff, num_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             ge;

   // bring down one bit, subtract when the partial remainder allows
   always_comb begin
      trial   = {rem_ff, num_ff[N_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         q_in   = {q_ff[Q_W-2:0], ge};
         ovf_in = ovf_ff | q_ff[Q_W-1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign quotient  = q_ff;

endmodule
